FILE: rtl/core/transfer_script_recognizer_core_assert.svh
// Assertion macros shared by the core's modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef TRANSFER_SCRIPT_RECOGNIZER_CORE_ASSERT_SVH
`define TRANSFER_SCRIPT_RECOGNIZER_CORE_ASSERT_SVH
`ifndef SYNTH
// prop must hold at every edge out of reset
`define TSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// cond must never be true out of reset
`define TSR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TSR_ASSERT(lbl, prop, msg)
`define TSR_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/trs_pkg.sv
package trs_pkg;

  localparam int unsigned HashBytes  = 20;
  localparam int unsigned SeqLen     = 15;
  localparam int unsigned CallLen    = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW       = 5;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 80;

  localparam logic [7:0] OpNull    = 8'h0B;
  localparam logic [7:0] OpPushMin = 8'h10;
  localparam logic [7:0] OpPushMax = 8'h20;
  localparam logic [7:0] OpIntMax  = 8'h03;
  localparam logic [7:0] OpTag     = 8'h0C;
  localparam logic [7:0] OpLen20   = 8'h14;

  localparam logic [7:0] MidSeq [SeqLen] = '{
    8'h14, 8'hC0, 8'h1F, 8'h0C, 8'h08, 8'h74, 8'h72, 8'h61,
    8'h6e, 8'h73, 8'h66, 8'h65, 8'h72, 8'h0C, 8'h14};

  localparam logic [7:0] CallSeq [CallLen] = '{8'h41, 8'h62, 8'h7d, 8'h5b, 8'h52};

  localparam logic [7:0] MainHash [HashBytes] = '{
    8'hf5, 8'h63, 8'hea, 8'h40, 8'hbc, 8'h28, 8'h3d, 8'h4d, 8'h0e, 8'h05,
    8'hc4, 8'h8e, 8'ha3, 8'h05, 8'hb3, 8'hf2, 8'ha0, 8'h73, 8'h40, 8'hef};

  localparam logic [7:0] AltHash [HashBytes] = '{
    8'hcf, 8'h76, 8'he2, 8'h8b, 8'hd0, 8'h06, 8'h2c, 8'h4a, 8'h47, 8'h8e,
    8'he3, 8'h55, 8'h61, 8'h01, 8'h13, 8'h19, 8'hf3, 8'hcf, 8'ha4, 8'hd2};

  // One finished script, as handed from the parser to the result sequencer
  typedef struct packed {
    logic                          ok;
    logic                          main;
    logic [63:0]                   amount;
    logic [HashBytes-1:0][7:0]     dest;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } head_t;

endpackage

FILE: rtl/core/transfer_script_recognizer_core.sv
// Transfer script recognizer.
// Input stream (s_axis_*): one script byte per transfer in tdata, tlast on the
// final byte of a script. A byte is taken every cycle while tready is high.
// Output stream (m_axis_*): for every script a burst of 20 transfers, each
// carrying the verdict, the main-asset flag, the signed amount and one byte of
// the destination hash with its index; tlast marks the 20th transfer.
// With the burst sequencer idle, a finished script's result is written to the queue
// as its last byte is accepted and then loaded into the sequencer's output registers.
// A burst moves one transfer per cycle while the receiver holds tready high, and
// bursts of queued scripts follow each other without a gap.
// Throughput on the input: one byte per cycle. The byte parser and the burst
// sequencer are joined by a two-entry result queue; tready drops only while
// that queue holds two finished scripts, which happens when scripts shorter
// than a burst arrive or when the receiver stalls the output.
// Reset puts the parser at the start of a script, empties the queue and
// drops the output valid. A stalled receiver holds the current transfer.
module transfer_script_recognizer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [trs_pkg::InDataW-1:0]     s_axis_tdata,   // [7:0] script_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] recognized, [1] is_main_asset, [65:2] amount, [73:66] dest_byte,
  // [78:74] dest_index, [79] zero
  output logic [trs_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast
);

  trs_pkg::push_t q_push;
  trs_pkg::head_t q_head;
  logic           q_full;
  logic           q_pop;

  trs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push)
  );

  trs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  trs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: rtl/core/trs_front.sv
module trs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [trs_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          q_full_i,
  output trs_pkg::push_t                q_push_o
);

  typedef enum logic [3:0] {
    PhNull, PhAmtOp, PhAmt, PhDtag0, PhDtag1, PhDhash, PhStag0, PhStag1,
    PhShash, PhSeq, PhContract, PhCall, PhDone, PhFail
  } phase_e;

  localparam logic [4:0] HashLast = 5'(trs_pkg::HashBytes - 1);
  localparam logic [4:0] SeqLast  = 5'(trs_pkg::SeqLen - 1);
  localparam logic [4:0] CallLast = 5'(trs_pkg::CallLen - 1);

  phase_e                               phase_q, phase_d;
  logic [4:0]                           cnt_q, cnt_d;
  logic [63:0]                          acc_q, acc_d;
  logic [1:0]                           len_q, len_d;
  logic                                 done_q, done_d;
  logic                                 main_q, main_d;
  logic                                 alt_q, alt_d;
  logic [trs_pkg::HashBytes-1:0][7:0]   dest_q, dest_d;
  logic [7:0]                           b;
  logic [2:0]                           amt_last;
  logic                                 accept;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (len_q)
      2'd0: amt_last = 3'd0;
      2'd1: amt_last = 3'd1;
      2'd2: amt_last = 3'd3;
      2'd3: amt_last = 3'd7;
      default: amt_last = 3'd0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    len_d   = len_q;
    done_d  = done_q;
    main_d  = main_q;
    alt_d   = alt_q;
    dest_d  = dest_q;
    q_push_o = '0;

    if (accept) begin
      unique case (phase_q)
        PhNull: phase_d = (b == trs_pkg::OpNull) ? PhAmtOp : PhFail;
        PhAmtOp: begin
          if (b >= trs_pkg::OpPushMin && b <= trs_pkg::OpPushMax) begin
            acc_d   = 64'(b - trs_pkg::OpPushMin);
            phase_d = PhDtag0;
          end else if (b <= trs_pkg::OpIntMax) begin
            len_d   = b[1:0];
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = PhAmt;
          end else begin
            phase_d = PhFail;
          end
        end
        PhAmt: begin
          // place byte in its lane; on the final byte fill the upper lanes with its sign
          for (int j = 0; j < 8; j++) begin
            if (3'(j) == cnt_q[2:0]) begin
              acc_d[j*8 +: 8] = b;
            end else if (3'(j) > cnt_q[2:0] && cnt_q[2:0] == amt_last) begin
              acc_d[j*8 +: 8] = {8{b[7]}};
            end
          end
          if (cnt_q[2:0] == amt_last) begin
            cnt_d   = '0;
            phase_d = PhDtag0;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        PhDtag0: phase_d = (b == trs_pkg::OpTag) ? PhDtag1 : PhFail;
        PhDtag1: begin
          phase_d = (b == trs_pkg::OpLen20) ? PhDhash : PhFail;
          cnt_d   = '0;
        end
        PhDhash: begin
          dest_d[cnt_q] = b;
          if (cnt_q == HashLast) begin
            done_d  = 1'b1;
            cnt_d   = '0;
            phase_d = PhStag0;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        PhStag0: phase_d = (b == trs_pkg::OpTag) ? PhStag1 : PhFail;
        PhStag1: begin
          phase_d = (b == trs_pkg::OpLen20) ? PhShash : PhFail;
          cnt_d   = '0;
        end
        PhShash: begin
          if (cnt_q == HashLast) begin
            cnt_d   = '0;
            phase_d = PhSeq;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        PhSeq: begin
          if (b != trs_pkg::MidSeq[cnt_q[3:0]]) begin
            phase_d = PhFail;
          end else if (cnt_q == SeqLast) begin
            cnt_d   = '0;
            main_d  = 1'b1;
            alt_d   = 1'b1;
            phase_d = PhContract;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        PhContract: begin
          main_d = main_q && (b == trs_pkg::MainHash[cnt_q]);
          alt_d  = alt_q && (b == trs_pkg::AltHash[cnt_q]);
          if (cnt_q == HashLast) begin
            cnt_d   = '0;
            phase_d = (main_d || alt_d) ? PhCall : PhFail;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        PhCall: begin
          if (b != trs_pkg::CallSeq[cnt_q[2:0]]) begin
            phase_d = PhFail;
          end else if (cnt_q == CallLast) begin
            cnt_d   = '0;
            phase_d = PhDone;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        default: phase_d = PhFail;
      endcase

      if (s_axis_tlast) begin
        q_push_o.push       = 1'b1;
        q_push_o.rec.ok     = (phase_d == PhDone);
        q_push_o.rec.main   = (phase_d == PhDone) && main_d;
        q_push_o.rec.amount = (phase_d == PhDone) ? acc_d : '0;
        q_push_o.rec.dest   = done_d ? dest_d : '0;
        // back to the start of a script; the hash store is gated by done_d
        phase_d = PhNull;
        cnt_d   = '0;
        acc_d   = '0;
        len_d   = '0;
        done_d  = 1'b0;
        main_d  = 1'b1;
        alt_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNull;
      cnt_q   <= '0;
      acc_q   <= '0;
      len_q   <= '0;
      done_q  <= 1'b0;
      main_q  <= 1'b1;
      alt_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      done_q  <= done_d;
      main_q  <= main_d;
      alt_q   <= alt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q <= dest_d;
  end

endmodule

FILE: rtl/core/trs_fifo.sv
`include "transfer_script_recognizer_core_assert.svh"

module trs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trs_pkg::push_t  push_i,
  output logic            full_o,
  output trs_pkg::head_t  head_o,
  input  logic            pop_i
);

  localparam logic [trs_pkg::QCntW-1:0] Depth   = trs_pkg::QCntW'(trs_pkg::QueueDepth);
  localparam logic [trs_pkg::QPtrW-1:0] PtrLast = trs_pkg::QPtrW'(trs_pkg::QueueDepth - 1);

  trs_pkg::rec_t                mem_q [trs_pkg::QueueDepth];
  logic [trs_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [trs_pkg::QCntW-1:0]    cnt_q;
  logic                         do_push, do_pop;

  assign full_o       = (cnt_q == Depth);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.rec   = mem_q[rd_ptr_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.rec;
    end
  end

  `TSR_NEVER(a_push_full, push_i.push && full_o, "script result pushed into a full queue")
  `TSR_NEVER(a_pop_empty, pop_i && !head_o.valid, "pop from an empty queue")
  `TSR_ASSERT(a_cnt_range, cnt_q <= Depth, "queue fill count out of range")

endmodule

FILE: rtl/core/trs_back.sv
`include "transfer_script_recognizer_core_assert.svh"

module trs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  trs_pkg::head_t                 head_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [trs_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam logic [trs_pkg::IdxW-1:0] IdxLast = trs_pkg::IdxW'(trs_pkg::HashBytes - 1);

  logic                         active_q;
  logic [trs_pkg::IdxW-1:0]     idx_q;
  trs_pkg::rec_t                cur_q;
  logic                         xfer;
  logic                         load;

  assign xfer = active_q && m_axis_tready;
  // take the next script when idle or as the current burst's final transfer leaves
  assign load = head_i.valid && (!active_q || (xfer && idx_q == IdxLast));
  assign pop_o = load;

  assign m_axis_tvalid = active_q;
  assign m_axis_tlast  = (idx_q == IdxLast);
  assign m_axis_tdata  = {1'b0, idx_q, cur_q.dest[idx_q], cur_q.amount, cur_q.main, cur_q.ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      idx_q    <= '0;
    end else if (xfer) begin
      if (idx_q == IdxLast) begin
        active_q <= 1'b0;
        idx_q    <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= head_i.rec;
    end
  end

  `TSR_ASSERT(a_idx_range, idx_q <= IdxLast, "burst index past the last hash byte")
  `TSR_ASSERT(a_idx_step, (xfer && idx_q != IdxLast) |=> (idx_q == $past(idx_q) + 5'd1), "burst index skipped")
  `TSR_ASSERT(a_burst_end, (xfer && idx_q == IdxLast && !head_i.valid) |=> !active_q, "burst did not end")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import trs_pkg::*;

  localparam int StallLimit = 3000;
  localparam int LongHold   = 400;
  localparam int DrainWait  = 20;
  localparam int ItemTarget = 270;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } script_item_t;

  typedef struct packed {
    logic        recognized;
    logic        main_asset;
    logic [63:0] amount;
    logic [7:0]  dest_byte;
    logic [4:0]  dest_index;
    logic        last;
  } burst_beat_t;

  typedef enum logic [3:0] {
    S_NULL, S_AMT_OP, S_AMT, S_DTAG, S_DLEN, S_DHASH, S_STAG, S_SLEN, S_SHASH,
    S_MID, S_CONTRACT, S_CALL, S_DONE, S_REJECT
  } parse_state_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;  // [7:0] script_byte
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] recognized, [1] is_main_asset, [65:2] amount, [73:66] dest_byte,
  // [78:74] dest_index, [79] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  transfer_script_recognizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  script_item_t script_bytes_q[$];
  burst_beat_t  burst_due[$];
  int           mismatches = 0;

  // parser state mirrored by the predictor
  parse_state_e ps;
  int           fld_cnt;
  int           amt_len;
  logic [63:0]  amt_acc;
  logic [7:0]   dest_hash [HashBytes];
  logic         main_ok;
  logic         alt_ok;
  logic         dest_captured;

  task automatic clear_parser();
    ps = S_NULL;
    fld_cnt = 0;
    amt_len = 0;
    amt_acc = '0;
    foreach (dest_hash[i]) dest_hash[i] = '0;
    main_ok = 1'b1;
    alt_ok = 1'b1;
    dest_captured = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    int nbits;
    burst_beat_t beat;
    case (ps)
      S_NULL: ps = (b == OpNull) ? S_AMT_OP : S_REJECT;
      S_AMT_OP: begin
        if (b >= OpPushMin && b <= OpPushMax) begin
          amt_acc = 64'(b - OpPushMin);
          ps = S_DTAG;
        end else if (b <= OpIntMax) begin
          amt_len = 1 << b[1:0];
          amt_acc = '0;
          fld_cnt = 0;
          ps = S_AMT;
        end else begin
          ps = S_REJECT;
        end
      end
      S_AMT: begin
        amt_acc |= 64'(b) << (8 * (fld_cnt % 8));
        fld_cnt++;
        if (fld_cnt >= amt_len) begin
          // sign-extend from the top byte received
          nbits = 8 * amt_len;
          if (nbits < 64 && amt_acc[nbits-1]) amt_acc |= ~((64'd1 << nbits) - 64'd1);
          fld_cnt = 0;
          ps = S_DTAG;
        end
      end
      S_DTAG: ps = (b == OpTag) ? S_DLEN : S_REJECT;
      S_DLEN: begin
        ps = (b == OpLen20) ? S_DHASH : S_REJECT;
        fld_cnt = 0;
      end
      S_DHASH: begin
        dest_hash[fld_cnt] = b;
        fld_cnt++;
        if (fld_cnt >= HashBytes) begin
          dest_captured = 1'b1;
          fld_cnt = 0;
          ps = S_STAG;
        end
      end
      S_STAG: ps = (b == OpTag) ? S_SLEN : S_REJECT;
      S_SLEN: begin
        ps = (b == OpLen20) ? S_SHASH : S_REJECT;
        fld_cnt = 0;
      end
      S_SHASH: begin
        fld_cnt++;
        if (fld_cnt >= HashBytes) begin
          fld_cnt = 0;
          ps = S_MID;
        end
      end
      S_MID: begin
        if (b != MidSeq[fld_cnt]) begin
          ps = S_REJECT;
        end else begin
          fld_cnt++;
          if (fld_cnt >= SeqLen) begin
            fld_cnt = 0;
            main_ok = 1'b1;
            alt_ok = 1'b1;
            ps = S_CONTRACT;
          end
        end
      end
      S_CONTRACT: begin
        if (b != MainHash[fld_cnt]) main_ok = 1'b0;
        if (b != AltHash[fld_cnt]) alt_ok = 1'b0;
        fld_cnt++;
        if (fld_cnt >= HashBytes) begin
          fld_cnt = 0;
          ps = (main_ok || alt_ok) ? S_CALL : S_REJECT;
        end
      end
      S_CALL: begin
        if (b != CallSeq[fld_cnt]) begin
          ps = S_REJECT;
        end else begin
          fld_cnt++;
          if (fld_cnt >= CallLen) begin
            fld_cnt = 0;
            ps = S_DONE;
          end
        end
      end
      // anything past the call sequence, or after a mismatch, rejects
      default: ps = S_REJECT;
    endcase

    if (fin) begin
      for (int k = 0; k < HashBytes; k++) begin
        beat.recognized = (ps == S_DONE);
        beat.main_asset = beat.recognized && main_ok;
        beat.amount     = beat.recognized ? amt_acc : '0;
        beat.dest_byte  = dest_captured ? dest_hash[k] : '0;
        beat.dest_index = 5'(k);
        beat.last       = (k == HashBytes - 1);
        burst_due.push_back(beat);
      end
      clear_parser();
    end
  endtask

  // code -1: small push of val (0..16); code 0..3: integer of 1 << code bytes
  function automatic byte_q_t transfer_script(input int code, input logic [63:0] val,
                                              input logic main_asset);
    byte_q_t s;
    s.push_back(OpNull);
    if (code < 0) begin
      s.push_back(OpPushMin + val[7:0]);
    end else begin
      s.push_back(8'(code));
      for (int i = 0; i < (1 << code); i++) s.push_back(val[8*i +: 8]);
    end
    s.push_back(OpTag);
    s.push_back(OpLen20);
    repeat (HashBytes) s.push_back(8'($urandom));
    s.push_back(OpTag);
    s.push_back(OpLen20);
    repeat (HashBytes) s.push_back(8'($urandom));
    for (int i = 0; i < SeqLen; i++) s.push_back(MidSeq[i]);
    for (int i = 0; i < HashBytes; i++) s.push_back(main_asset ? MainHash[i] : AltHash[i]);
    for (int i = 0; i < CallLen; i++) s.push_back(CallSeq[i]);
    return s;
  endfunction

  task automatic queue_script(input byte_q_t s);
    script_item_t it;
    foreach (s[i]) begin
      it.data = s[i];
      it.last = (i == s.size() - 1);
      script_bytes_q.push_back(it);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    byte_q_t     s;
    int          code;
    int          p;
    int          idx;
    int          room;
    logic [63:0] val;

    clear_parser();

    // early ends, wrong null opcode, amount opcodes out of range
    queue_script('{OpNull});
    queue_script('{8'h00});
    queue_script('{OpNull, OpPushMin});
    queue_script('{OpNull, OpIntMax + 8'd1, OpTag});
    queue_script('{OpNull, OpPushMin - 8'd1, 8'hFF});
    queue_script('{OpNull, OpPushMax + 8'd1});
    queue_script('{OpNull, 8'hFF});

    // narrowest and widest integer amounts with the sign bit set, both assets
    queue_script(transfer_script(0, 64'h80, 1'b1));
    queue_script(transfer_script(3, 64'h8000_0000_0000_0000, 1'b0));

    // random scripts, the last one cut to the byte budget
    while (script_bytes_q.size() < ItemTarget) begin
      code = int'($urandom_range(0, 4)) - 1;
      val = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 1) ? '1 : '0;
      if (code < 0) val = $urandom_range(0, 16);
      s = transfer_script(code, val, 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
        5: s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
        6: repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
        7: repeat ($urandom_range(1, 3)) s.push_back(8'($urandom));
        8: begin
          p = $urandom_range(0, HashBytes - 1);
          idx = s.size() - CallLen - HashBytes + p;
          s[idx] = (s[idx] == MainHash[p]) ? AltHash[p] : MainHash[p];
        end
        9: begin
          s.delete();
          repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
          if ($urandom_range(0, 1)) s[0] = OpNull;
        end
        default: ;
      endcase
      room = ItemTarget - script_bytes_q.size();
      while (s.size() > room) void'(s.pop_back());
      queue_script(s);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (script_bytes_q.size() != 0 || burst_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // byte driver
  int in_gap = 0;
  int in_calm = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        void'(script_bytes_q.pop_front());
      end
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 149) == 0) in_calm = $urandom_range(40, 150);
      // hold an offered byte until its transfer completes
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (script_bytes_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= script_bytes_q[0].data;
          s_axis_tlast  <= script_bytes_q[0].last;
          in_gap = (in_calm > 0) ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  int out_hold = 0;
  int out_calm = 0;
  int beats_taken = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) beats_taken++;
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 149) == 0) out_calm = $urandom_range(40, 150);
      if (out_hold > 0) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && beats_taken >= 60) begin
        long_hold_done = 1'b1;
        out_hold = LongHold;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_hold = (out_calm > 0) ? 0 : pick_gap();
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    burst_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (burst_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = burst_due.pop_front();
        check_field("recognized", 64'(want.recognized), 64'(m_axis_tdata[0]));
        check_field("is_main_asset", 64'(want.main_asset), 64'(m_axis_tdata[1]));
        check_field("amount", want.amount, m_axis_tdata[65:2]);
        check_field("dest_byte", 64'(want.dest_byte), 64'(m_axis_tdata[73:66]));
        check_field("dest_index", 64'(want.dest_index), 64'(m_axis_tdata[78:74]));
        check_field("last", 64'(want.last), 64'(m_axis_tlast));
      end
    end
  end

  // stall watchdog
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/trs_pkg.sv
rtl/core/trs_front.sv
rtl/core/trs_fifo.sv
rtl/core/trs_back.sv
rtl/core/transfer_script_recognizer_core.sv
sim/testbench.sv
